FILE: rtl/core/assert_macros.svh
// Assertion macros for the hasher core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/sha256_pkg.sv
// Types, constants and functions shared by the SHA-256 core
`timescale 1ns / 1ps
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam word_t H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // Datapath operations requested by the controller
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_BYTE   = 3'd1; // store input byte, bump counts
    localparam logic [2:0] OP_PAD    = 3'd2; // store pad or zero or length byte
    localparam logic [2:0] OP_START  = 3'd3; // load working words from chain
    localparam logic [2:0] OP_ROUND  = 3'd4; // one compression round
    localparam logic [2:0] OP_FOLD   = 3'd5; // add working words into chain
    localparam logic [2:0] OP_SHIFT  = 3'd6; // rotate chain for digest output
    localparam logic [2:0] OP_CLEAR  = 3'd7; // reset chain and counts

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] round;  // round index for OP_ROUND
        logic [5:0] pad_pos; // buffer position for OP_PAD
        logic       len_blk; // padded block ends with the bit length
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;      // bytes in the buffer
        logic       block_full; // last OP_BYTE filled the block
    } dp_stat_t;

    function automatic word_t ror32(word_t v, int unsigned n);
        ror32 = (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: rtl/core/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte-stream hasher core
`timescale 1ns / 1ps
// Takes a message one byte per beat and returns the eight SHA-256 digest
// words after a beat marked last. A byte beat passes a check state before
// the next beat is taken; a beat that fills the 64-byte block starts the
// one-round-per-cycle compression. Closing a message writes the padding
// one byte per cycle and compresses once or twice, then emits eight beats.
module sha256_byte_stream_hasher_core
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

`include "assert_macros.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sha256_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_has_byte   (s_has_byte),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_word_index (m_word_index),
        .m_last_word  (m_last_word),
        .stat         (stat),
        .cmd          (cmd)
    );

    sha256_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_byte   (s_data_byte),
        .stat      (stat),
        .head_word (m_digest_word)
    );

    `ASSERT_IMPLIES(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "input during output")
    `ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_last_word, s_ready, "no idle")
    `ASSERT_IMPLIES(a_shift_only_out, aclk, aresetn, cmd.op == OP_SHIFT, m_valid && m_ready, "bad shift")

endmodule

FILE: rtl/core/sha256_datapath.sv
// Datapath: block buffer, message schedule, round logic and chain words
`timescale 1ns / 1ps
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  dp_cmd_t    cmd,
    input  logic [7:0] in_byte,
    output dp_stat_t   stat,
    output word_t      head_word
);

    word_t       w_reg [16];
    word_t       chain_reg [8];
    word_t       work_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic        full_reg;

    word_t w_cur, w_new, s0, s1, t1, t2, ch, maj, sig0, sig1;
    word_t a, b, c, e, f, g, h;
    logic [7:0] pad_val;
    logic [5:0] len_sh;

    assign stat.fill       = fill_reg;
    assign stat.block_full = full_reg;
    assign head_word       = chain_reg[0];

    // Schedule word: first 16 from the buffer, then the rolling window
    always_comb begin
        s0    = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = (cmd.round < 6'd16) ? w_reg[cmd.round[3:0]] : w_new;
    end

    // One round of compression
    always_comb begin
        a = work_reg[0]; b = work_reg[1]; c = work_reg[2];
        e = work_reg[4]; f = work_reg[5]; g = work_reg[6]; h = work_reg[7];
        sig1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
        sig0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
        ch   = (e & f) ^ (~e & g);
        maj  = (a & b) ^ (a & c) ^ (b & c);
        t1   = h + sig1 + ch + ROUND_K[cmd.round] + w_cur;
        t2   = sig0 + maj;
    end

    // Padding byte: length in the closing block, else pad marker or zero fill
    always_comb begin
        len_sh = 6'((7 - int'(cmd.pad_pos[2:0])) * 8);
        if (cmd.len_blk && cmd.pad_pos >= LEN_POS) begin
            pad_val = 8'(len_reg >> len_sh);
        end else if (cmd.pad_pos == fill_reg) begin
            pad_val = PAD_BYTE;
        end else begin
            pad_val = 8'h00;
        end
    end

    // Schedule window, working words, chain words, counts; bytes land in the
    // schedule window in big-endian order, so it doubles as the block buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            len_reg  <= '0;
            full_reg <= 1'b0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= H_INIT[i];
        end else begin
            unique case (cmd.op)
                OP_BYTE: begin
                    w_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= in_byte;
                    fill_reg <= fill_reg + 6'd1;
                    len_reg  <= len_reg + 64'd8;
                    full_reg <= (fill_reg == 6'd63);
                end
                OP_PAD: begin
                    w_reg[cmd.pad_pos[5:2]][{~cmd.pad_pos[1:0], 3'b000} +: 8] <= pad_val;
                end
                OP_START: begin
                    for (int i = 0; i < 8; i++) work_reg[i] <= chain_reg[i];
                end
                OP_ROUND: begin
                    work_reg[0] <= t1 + t2;
                    work_reg[1] <= a;
                    work_reg[2] <= b;
                    work_reg[3] <= c;
                    work_reg[4] <= work_reg[3] + t1;
                    work_reg[5] <= e;
                    work_reg[6] <= f;
                    work_reg[7] <= g;
                    // Advance the window once the stored words are used up
                    if (cmd.round >= 6'd16) begin
                        for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                        w_reg[15] <= w_new;
                    end
                end
                OP_FOLD: begin
                    for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + work_reg[i];
                    full_reg <= 1'b0;
                end
                OP_SHIFT: begin
                    for (int i = 0; i < 7; i++) chain_reg[i] <= chain_reg[i+1];
                    chain_reg[7] <= chain_reg[0];
                end
                OP_CLEAR: begin
                    fill_reg <= '0;
                    len_reg  <= '0;
                    full_reg <= 1'b0;
                    for (int i = 0; i < 8; i++) chain_reg[i] <= H_INIT[i];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/sha256_ctrl.sv
// Controller: sequences byte intake, compression, padding and digest output
`timescale 1ns / 1ps
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_has_byte,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_word_index,
    output logic       m_last_word,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_PAD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [2:0] idx_reg, idx_next;
    logic       last_reg, last_next;   // message closes after this block
    logic       final_reg, final_next; // block under way holds the length

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_word_index = idx_reg;
    assign m_last_word  = (idx_reg == 3'd7);

    // Next state and datapath command
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        final_next = final_reg;
        cmd        = '{op: OP_NONE, round: cnt_reg, pad_pos: cnt_reg, len_blk: final_reg};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next  = s_is_last;
                    final_next = 1'b0;
                    if (s_has_byte) begin
                        cmd.op     = OP_BYTE;
                        state_next = ST_CHECK;
                    end else if (s_is_last) begin
                        cnt_next   = stat.fill;
                        final_next = (stat.fill < LEN_POS);
                        state_next = ST_PAD;
                    end
                end
            end
            ST_CHECK: begin
                if (stat.block_full) begin
                    state_next = ST_START;
                end else if (last_reg) begin
                    cnt_next   = stat.fill;
                    final_next = (stat.fill < LEN_POS);
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                // Write the pad marker, zero fill and length, one byte a cycle
                cmd.op   = OP_PAD;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.op     = OP_START;
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.op   = OP_ROUND;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.op = OP_FOLD;
                if (final_reg) begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end else if (last_reg) begin
                    // closing block: after a full data block the marker sits at
                    // zero; after a marker overflow only zeros and length remain
                    cnt_next   = (stat.fill > 6'd55) ? 6'd0 : stat.fill;
                    final_next = 1'b1;
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    cmd.op   = OP_SHIFT;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.op     = OP_CLEAR;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            final_reg <= final_next;
        end
    end

endmodule

FILE: verif/sha256_byte_stream_hasher_core_test.sv
// Self-checking testbench for the SHA-256 byte-stream hasher core
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_core_test;
    import sha256_pkg::*;

    // Running SHA-256 state and queue of digest words still owed by the core
    class digest_scoreboard;
        word_t       chain [8];
        logic [7:0]  buffer [64];
        int unsigned fill;
        logic [63:0] bit_len;
        word_t       owed_word [$];
        logic [2:0]  owed_index [$];
        logic        owed_last [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
            for (int i = 0; i < 64; i++) buffer[i] = 8'h00;
            fill = 0;
            bit_len = 64'd0;
        endfunction

        function word_t rotr(word_t v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        // Run the 64 rounds over the buffer and fold into the chain
        function void compress();
            word_t w [64];
            word_t a, b, c, d, e, f, g, h, t1, t2, x, y;
            for (int i = 0; i < 16; i++)
                w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
            for (int i = 16; i < 64; i++) begin
                x = w[i-15];
                y = w[i-2];
                w[i] = (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10)) + w[i-7]
                     + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-16];
            end
            {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                        chain[4], chain[5], chain[6], chain[7]};
            for (int i = 0; i < 64; i++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
                   + ((e & f) ^ (~e & g)) + ROUND_K[i] + w[i];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
                   + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        // Note one accepted input beat
        function void note_input(logic [7:0] data, logic has, logic last);
            int unsigned pos;
            if (has) begin
                buffer[fill] = data;
                bit_len += 64'd8;
                fill++;
                if (fill == 64) begin
                    compress();
                    fill = 0;
                end
            end
            if (!last) return;
            pos = fill;
            buffer[pos++] = PAD_BYTE;
            if (pos > LEN_POS) begin
                while (pos < 64) buffer[pos++] = 8'h00;
                compress();
                pos = 0;
            end
            while (pos < LEN_POS) buffer[pos++] = 8'h00;
            for (int i = 0; i < 8; i++) buffer[LEN_POS + i] = bit_len[63 - 8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                owed_word.push_back(chain[i]);
                owed_index.push_back(i[2:0]);
                owed_last.push_back(i == 7);
            end
            restart();
        endfunction

        // Check one accepted digest beat against the oldest owed word
        function void check_output(word_t word, logic [2:0] idx, logic last);
            word_t ew;
            logic [2:0] ei;
            logic el;
            if (owed_word.size() == 0) begin
                $error("unexpected digest beat word=%h index=%0d", word, idx);
                errors++;
                return;
            end
            ew = owed_word.pop_front();
            ei = owed_index.pop_front();
            el = owed_last.pop_front();
            if (word !== ew) begin
                $error("digest_word expected %h actual %h", ew, word);
                errors++;
            end
            if (idx !== ei) begin
                $error("word_index expected %0d actual %0d", ei, idx);
                errors++;
            end
            if (last !== el) begin
                $error("last_word expected %0d actual %0d", el, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_has_byte;
    logic        s_is_last;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    digest_scoreboard board;
    int unsigned      cycle_count;
    bit               hold_off;
    bit               feeding_done;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    sha256_byte_stream_hasher_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_has_byte    (s_has_byte),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && s_valid && s_ready)
            board.note_input(s_data_byte, s_has_byte, s_is_last);
        if (aresetn && m_valid && m_ready)
            board.check_output(m_digest_word, m_word_index, m_last_word);
    end

    // Stall the receiver on its own pattern, with one long hold-off
    initial begin
        int unsigned mode;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                mode = (cycle_count / 300) % 3;
                if (mode == 0) m_ready <= 1'b1;
                else if (mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
                else m_ready <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // Offer one beat and hold it until accepted
    task automatic send_beat(logic [7:0] data, logic has, logic last);
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_has_byte  <= has;
        s_is_last   <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic pause(int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // Send a message of given length with random bytes, then close it
    task automatic send_message(int unsigned len, bit close_with_byte);
        int unsigned burst;
        burst = $urandom_range(1, 40);
        for (int unsigned i = 0; i < len; i++) begin
            send_beat(8'($urandom_range(0, 255)), 1'b1, close_with_byte && (i == len - 1));
            if (--burst == 0) begin
                pause($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
                burst = $urandom_range(1, 40);
            end
        end
        if (!close_with_byte || len == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Timeout watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int unsigned len;
        board = new();
        cycle_count = 0;
        hold_off = 1'b0;
        feeding_done = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = 8'h00;
        s_has_byte = 1'b0;
        s_is_last = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty message, ignored beats, extreme bytes
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'hA5, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b0, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'hAA, 1'b0, 1'b1);

        // Block-boundary lengths: 55 and 56 straddle the length field, 64 fills a block
        send_message(55, 1'b1);
        send_message(56, 1'b0);
        send_message(64, 1'b1);

        // Long hold-off: receiver stops while messages keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                send_message(3, 1'b1);
                send_message(0, 1'b0);
                send_message(5, 1'b0);
            end
        join

        // Random messages, mostly short, a few across blocks, some stray beats
        for (int m = 0; m < 10; m++) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(56, 130);
                1: len = 0;
                default: len = $urandom_range(1, 12);
            endcase
            if ($urandom_range(0, 4) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 20));
        end
        s_valid <= 1'b0;

        // Drain, then allow a little settle time
        while (board.owed_word.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
